// ===== hdl/mips16_instruction_expander_defines.svh =====
// ---------------------------------------------------------------------------
// MIPS16 instruction expander assertion macros
// Shared property templates for the expander pipeline checks.
// ---------------------------------------------------------------------------
`ifndef MIPS16_INSTRUCTION_EXPANDER_DEFINES_SVH
`define MIPS16_INSTRUCTION_EXPANDER_DEFINES_SVH

// Implication checked every clock while out of reset.
`define M16X_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset.
`define M16X_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/m16x_pkg.sv =====
// ---------------------------------------------------------------------------
// MIPS16 expander package
// Opcodes, result codes, stage structs and register map helper.
// ---------------------------------------------------------------------------
`default_nettype none

package m16x_pkg;

    localparam logic [1:0] OUT_WORD     = 2'd0;
    localparam logic [1:0] OUT_DIRECT   = 2'd1;
    localparam logic [1:0] OUT_RESERVED = 2'd2;
    localparam logic [1:0] OUT_NOTCOV   = 2'd3;

    localparam logic [3:0] PK_NONE    = 4'd0;
    localparam logic [3:0] PK_ADDIUPC = 4'd1;
    localparam logic [3:0] PK_B       = 4'd2;
    localparam logic [3:0] PK_JAL     = 4'd3;
    localparam logic [3:0] PK_JALX    = 4'd4;
    localparam logic [3:0] PK_BEQZ    = 4'd5;
    localparam logic [3:0] PK_BNEZ    = 4'd6;
    localparam logic [3:0] PK_LWPC    = 4'd7;
    localparam logic [3:0] PK_JALR    = 4'd8;

    localparam logic [5:0] OP_ADDIU  = 6'h09;
    localparam logic [5:0] OP_SLTI   = 6'h0A;
    localparam logic [5:0] OP_SLTIU  = 6'h0B;
    localparam logic [5:0] OP_ORI    = 6'h0D;
    localparam logic [5:0] OP_XORI   = 6'h0E;
    localparam logic [5:0] OP_DADDIU = 6'h19;
    localparam logic [5:0] OP_LB     = 6'h20;
    localparam logic [5:0] OP_LH     = 6'h21;
    localparam logic [5:0] OP_LW     = 6'h23;
    localparam logic [5:0] OP_LBU    = 6'h24;
    localparam logic [5:0] OP_LHU    = 6'h25;
    localparam logic [5:0] OP_LWU    = 6'h27;
    localparam logic [5:0] OP_SB     = 6'h28;
    localparam logic [5:0] OP_SH     = 6'h29;
    localparam logic [5:0] OP_SW     = 6'h2B;
    localparam logic [5:0] OP_LD     = 6'h37;
    localparam logic [5:0] OP_SD     = 6'h3F;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_DSLLV   = 6'h14;
    localparam logic [5:0] FN_DSRLV   = 6'h16;
    localparam logic [5:0] FN_DSRAV   = 6'h17;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_DMULT   = 6'h1C;
    localparam logic [5:0] FN_DMULTU  = 6'h1D;
    localparam logic [5:0] FN_DDIV    = 6'h1E;
    localparam logic [5:0] FN_DDIVU   = 6'h1F;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;
    localparam logic [5:0] FN_DADDU   = 6'h2D;
    localparam logic [5:0] FN_DSUBU   = 6'h2F;
    localparam logic [5:0] FN_DSLL    = 6'h38;
    localparam logic [5:0] FN_DSRL    = 6'h3A;
    localparam logic [5:0] FN_DSRA    = 6'h3B;

    localparam logic [4:0] REG_T  = 5'd24;
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;

    localparam logic [31:0] SEG_MASK = 32'hF000_0000;

    // Address adder selection chosen by the decode stage.
    localparam logic [1:0] AS_NONE = 2'd0;
    localparam logic [1:0] AS_PC2  = 2'd1;  // pc + 2 + offset
    localparam logic [1:0] AS_BASE = 2'd2;  // (base & ~3) + offset
    localparam logic [1:0] AS_JUMP = 2'd3;  // segment of pc + 4 | index

    // Stage 1 -> stage 2: decoded fields plus address operands.
    typedef struct packed {
        logic [1:0]  outcome;
        logic [31:0] word;
        logic [3:0]  kind;
        logic [4:0]  src;
        logic [4:0]  dst;
        logic        ends;
        logic        isbr;
        logic        need64;
        logic [1:0]  asel;
        logic [31:0] offset;
        logic [31:0] pc;
        logic [31:0] base;
    } dec_t;

    // Resolve -> stage 2 output register and output: final result.
    typedef struct packed {
        logic [1:0]  outcome;
        logic [31:0] word;
        logic [3:0]  kind;
        logic [31:0] target;
        logic [4:0]  src;
        logic [4:0]  dst;
        logic        ends;
        logic        isbr;
    } res_t;

    function automatic logic [4:0] map3(input logic [2:0] v);
        logic [4:0] r;
        unique case (v)
            3'd0:    r = 5'd16;
            3'd1:    r = 5'd17;
            default: r = {2'b00, v};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/m16x_decode.sv =====
// ---------------------------------------------------------------------------
// MIPS16 expander decode logic
// Combinational decode of one halfword (plus the second for JAL/JALX) into word or placement fields.
// ---------------------------------------------------------------------------
`default_nettype none

module m16x_decode (
    input  wire logic [15:0]  half_first,
    input  wire logic [15:0]  half_second,
    input  wire logic [31:0]  insn_addr,
    input  wire logic [31:0]  base_addr,
    output m16x_pkg::dec_t    dec
);
    import m16x_pkg::*;

    function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [4:0] sa,
                                          input logic [5:0] fn);
        return {6'd0, rs, rt, rd, sa, fn};
    endfunction

    logic [15:0] h;
    logic [4:0]  rx, ry, rz, i5, sa_sh, sa_rr;
    logic [7:0]  i8;
    logic [15:0] i8x4, i5x8, i5x4, i5x2, i8s, i4s, i8sx8;

    assign h     = half_first;
    assign rx    = map3(h[10:8]);
    assign ry    = map3(h[7:5]);
    assign rz    = map3(h[4:2]);
    assign i8    = h[7:0];
    assign i5    = h[4:0];
    assign i8x4  = {6'd0, i8, 2'b00};
    assign i5x8  = {8'd0, i5, 3'b000};
    assign i5x4  = {9'd0, i5, 2'b00};
    assign i5x2  = {10'd0, i5, 1'b0};
    assign i8s   = {{8{i8[7]}}, i8};
    assign i4s   = {{12{h[3]}}, h[3:0]};
    assign i8sx8 = {{5{i8[7]}}, i8, 3'b000};
    // Three-bit shift amount of zero means eight.
    assign sa_sh = (h[4:2] == 3'd0) ? 5'd8 : {2'b00, h[4:2]};
    assign sa_rr = (h[10:8] == 3'd0) ? 5'd8 : {2'b00, h[10:8]};

    always_comb begin
        dec         = '0;
        dec.pc      = insn_addr;
        dec.base    = base_addr;
        dec.outcome = OUT_WORD;
        unique case (h[15:11])
            5'h00: dec.word = itype(OP_ADDIU, REG_SP, rx, i8x4);
            5'h01: begin
                dec.outcome = OUT_DIRECT; dec.kind = PK_ADDIUPC; dec.dst = rx;
                dec.asel = AS_BASE; dec.offset = {22'd0, i8, 2'b00};
            end
            5'h02: begin
                dec.outcome = OUT_DIRECT; dec.kind = PK_B; dec.ends = 1'b1;
                dec.asel = AS_PC2; dec.offset = {{20{h[10]}}, h[10:0], 1'b0};
            end
            5'h03: begin
                dec.outcome = OUT_DIRECT; dec.kind = h[10] ? PK_JALX : PK_JAL;
                dec.isbr = 1'b1; dec.asel = AS_JUMP;
                dec.offset = {4'd0, h[4:0], h[9:5], half_second, 2'b00};
            end
            5'h04, 5'h05: begin
                dec.outcome = OUT_DIRECT; dec.kind = h[11] ? PK_BNEZ : PK_BEQZ;
                dec.src = rx; dec.ends = 1'b1;
                dec.asel = AS_PC2; dec.offset = {{23{i8[7]}}, i8, 1'b0};
            end
            5'h06: begin
                unique case (h[1:0])
                    2'd0: dec.word = rtype(5'd0, ry, rx, sa_sh, FN_SLL);
                    2'd1: begin
                        dec.word = rtype(5'd0, ry, rx, sa_sh, FN_DSLL); dec.need64 = 1'b1;
                    end
                    2'd2: dec.word = rtype(5'd0, ry, rx, sa_sh, FN_SRL);
                    default: dec.word = rtype(5'd0, ry, rx, sa_sh, FN_SRA);
                endcase
            end
            5'h07: begin dec.word = itype(OP_LD, rx, ry, i5x8); dec.need64 = 1'b1; end
            5'h08: begin
                if (h[4]) begin
                    dec.word = itype(OP_DADDIU, rx, ry, i4s); dec.need64 = 1'b1;
                end else begin
                    dec.word = itype(OP_ADDIU, rx, ry, i4s);
                end
            end
            5'h09: dec.word = itype(OP_ADDIU, rx, rx, i8s);
            5'h0A: dec.word = itype(OP_SLTI, rx, REG_T, {8'd0, i8});
            5'h0B: dec.word = itype(OP_SLTIU, rx, REG_T, {8'd0, i8});
            5'h0C: begin
                unique case (h[10:8])
                    3'd0, 3'd1: begin
                        dec.outcome = OUT_DIRECT; dec.kind = h[8] ? PK_BNEZ : PK_BEQZ;
                        dec.src = REG_T; dec.ends = 1'b1;
                        dec.asel = AS_PC2; dec.offset = {{23{i8[7]}}, i8, 1'b0};
                    end
                    3'd2: dec.word = itype(OP_SW, REG_SP, REG_RA, i8x4);
                    3'd3: dec.word = itype(OP_ADDIU, REG_SP, REG_SP, i8sx8);
                    3'd5: dec.word = rtype(map3(h[2:0]), 5'd0, {h[4:3], h[7:5]}, 5'd0, FN_OR);
                    3'd7: dec.word = rtype(i5, 5'd0, ry, 5'd0, FN_OR);
                    default: dec.outcome = OUT_RESERVED;
                endcase
            end
            5'h0D: dec.word = itype(OP_ORI, 5'd0, rx, {8'd0, i8});
            5'h0E: dec.word = itype(OP_XORI, rx, REG_T, {8'd0, i8});
            5'h0F: begin dec.word = itype(OP_SD, rx, ry, i5x8); dec.need64 = 1'b1; end
            5'h10: dec.word = itype(OP_LB, rx, ry, {11'd0, i5});
            5'h11: dec.word = itype(OP_LH, rx, ry, i5x2);
            5'h12: dec.word = itype(OP_LW, REG_SP, rx, i8x4);
            5'h13: dec.word = itype(OP_LW, rx, ry, i5x4);
            5'h14: dec.word = itype(OP_LBU, rx, ry, {11'd0, i5});
            5'h15: dec.word = itype(OP_LHU, rx, ry, i5x2);
            5'h16: begin
                dec.outcome = OUT_DIRECT; dec.kind = PK_LWPC; dec.dst = rx;
                dec.asel = AS_BASE; dec.offset = {22'd0, i8, 2'b00};
            end
            5'h17: begin dec.word = itype(OP_LWU, rx, ry, i5x4); dec.need64 = 1'b1; end
            5'h18: dec.word = itype(OP_SB, rx, ry, {11'd0, i5});
            5'h19: dec.word = itype(OP_SH, rx, ry, i5x2);
            5'h1A: dec.word = itype(OP_SW, REG_SP, rx, i8x4);
            5'h1B: dec.word = itype(OP_SW, rx, ry, i5x4);
            5'h1C: begin
                unique case (h[1:0])
                    2'd0: begin
                        dec.word = rtype(rx, ry, rz, 5'd0, FN_DADDU); dec.need64 = 1'b1;
                    end
                    2'd1: dec.word = rtype(rx, ry, rz, 5'd0, FN_ADDU);
                    2'd2: begin
                        dec.word = rtype(rx, ry, rz, 5'd0, FN_DSUBU); dec.need64 = 1'b1;
                    end
                    default: dec.word = rtype(rx, ry, rz, 5'd0, FN_SUBU);
                endcase
            end
            5'h1D: begin
                unique case (h[4:0])
                    5'h00: begin
                        unique case (h[7:5])
                            3'd0: dec.word = rtype(rx, 5'd0, 5'd0, 5'd0, FN_JR);
                            3'd1: dec.word = rtype(REG_RA, 5'd0, 5'd0, 5'd0, FN_JR);
                            3'd2: begin
                                dec.outcome = OUT_DIRECT; dec.kind = PK_JALR;
                                dec.src = rx; dec.isbr = 1'b1;
                            end
                            default: dec.outcome = OUT_RESERVED;
                        endcase
                    end
                    5'h02: dec.word = rtype(rx, ry, REG_T, 5'd0, FN_SLT);
                    5'h03: dec.word = rtype(rx, ry, REG_T, 5'd0, FN_SLTU);
                    5'h04: dec.word = rtype(rx, ry, ry, 5'd0, FN_SLLV);
                    // Break code sits in the shift-amount and rd fields.
                    5'h05: dec.word = {20'd0, h[10:5], FN_BREAK};
                    5'h06: dec.word = rtype(rx, ry, ry, 5'd0, FN_SRLV);
                    5'h07: dec.word = rtype(rx, ry, ry, 5'd0, FN_SRAV);
                    5'h08: begin
                        dec.word = rtype(5'd0, ry, ry, sa_rr, FN_DSRL); dec.need64 = 1'b1;
                    end
                    5'h09: dec.word = {26'd0, FN_SYSCALL};
                    5'h0A: dec.word = rtype(rx, ry, REG_T, 5'd0, FN_XOR);
                    5'h0B: dec.word = rtype(5'd0, ry, rx, 5'd0, FN_SUBU);
                    5'h0C: dec.word = rtype(rx, ry, rx, 5'd0, FN_AND);
                    5'h0D: dec.word = rtype(rx, ry, rx, 5'd0, FN_OR);
                    5'h0E: dec.word = rtype(rx, ry, rx, 5'd0, FN_XOR);
                    5'h0F: dec.word = rtype(ry, 5'd0, rx, 5'd0, FN_NOR);
                    5'h10: dec.word = rtype(5'd0, 5'd0, rx, 5'd0, FN_MFHI);
                    5'h12: dec.word = rtype(5'd0, 5'd0, rx, 5'd0, FN_MFLO);
                    5'h13: begin
                        dec.word = rtype(5'd0, ry, ry, sa_rr, FN_DSRA); dec.need64 = 1'b1;
                    end
                    5'h14: begin
                        dec.word = rtype(rx, ry, ry, 5'd0, FN_DSLLV); dec.need64 = 1'b1;
                    end
                    5'h16: begin
                        dec.word = rtype(rx, ry, ry, 5'd0, FN_DSRLV); dec.need64 = 1'b1;
                    end
                    5'h17: begin
                        dec.word = rtype(rx, ry, ry, 5'd0, FN_DSRAV); dec.need64 = 1'b1;
                    end
                    5'h18: dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_MULT);
                    5'h19: dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_MULTU);
                    5'h1A: dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_DIV);
                    5'h1B: dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_DIVU);
                    5'h1C: begin
                        dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_DMULT); dec.need64 = 1'b1;
                    end
                    5'h1D: begin
                        dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_DMULTU); dec.need64 = 1'b1;
                    end
                    5'h1E: begin
                        dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_DDIV); dec.need64 = 1'b1;
                    end
                    5'h1F: begin
                        dec.word = rtype(rx, ry, 5'd0, 5'd0, FN_DDIVU); dec.need64 = 1'b1;
                    end
                    default: dec.outcome = OUT_RESERVED;
                endcase
            end
            default: dec.outcome = OUT_NOTCOV;
        endcase
        // Reserved and uncovered cells carry no word.
        if (dec.outcome == OUT_RESERVED || dec.outcome == OUT_NOTCOV) begin
            dec.word = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/m16x_resolve.sv =====
// ---------------------------------------------------------------------------
// MIPS16 expander resolve logic
// Target address add and doubleword gating on a decoded item.
// ---------------------------------------------------------------------------
`default_nettype none

module m16x_resolve (
    input  wire logic           allow_64bit,
    input  m16x_pkg::dec_t      dec,
    output m16x_pkg::res_t      res
);
    import m16x_pkg::*;

    logic [31:0] pc4;

    assign pc4 = dec.pc + 32'd4;

    always_comb begin
        res         = '0;
        res.outcome = dec.outcome;
        res.word    = dec.word;
        res.kind    = dec.kind;
        res.src     = dec.src;
        res.dst     = dec.dst;
        res.ends    = dec.ends;
        res.isbr    = dec.isbr;
        unique case (dec.asel)
            AS_PC2:  res.target = dec.pc + 32'd2 + dec.offset;
            AS_BASE: res.target = {dec.base[31:2], 2'b00} + dec.offset;
            AS_JUMP: res.target = (pc4 & SEG_MASK) | dec.offset;
            default: res.target = '0;
        endcase
        // Doubleword forms are reserved while 64-bit support is off.
        if (dec.need64 && !allow_64bit) begin
            res         = '0;
            res.outcome = OUT_RESERVED;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mips16_instruction_expander.sv =====
// ---------------------------------------------------------------------------
// MIPS16 instruction expander
// Expands non-extended MIPS16 halfwords into standard words or placements.
// ---------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | half_first, half_second, insn_addr, base_addr
//  m_*      | out       | outcome, word, kind, target, src/dst regs, flags
//  cfg_*    | in        | allow_64bit write data
//
// Three register stages: input capture, decoded fields, output register (after address add and gating).
// One request enters every cycle when m_ready holds.
// A stage advances when it is empty or the stage after it advances, so a stall
// ripples back without loss or repeat. Reset clears valid bits and allow_64bit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mips16_instruction_expander_defines.svh"

module mips16_instruction_expander (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_valid,
    output wire logic        s_ready,
    input  wire logic [15:0] s_half_first,
    input  wire logic [15:0] s_half_second,
    input  wire logic [31:0] s_insn_addr,
    input  wire logic [31:0] s_base_addr,
    output wire logic        m_valid,
    input  wire logic        m_ready,
    output wire logic [1:0]  m_outcome,
    output wire logic [31:0] m_expanded_word,
    output wire logic [3:0]  m_place_kind,
    output wire logic [31:0] m_target_addr,
    output wire logic [4:0]  m_src_reg,
    output wire logic [4:0]  m_dst_reg,
    output wire logic        m_compact_br,
    output wire logic        m_link_jump
);
    import m16x_pkg::*;

    logic   allow_reg;
    logic   v0_reg, v1_reg, v2_reg;
    logic   adv0, adv1, adv2;
    logic [15:0] hf_reg, hs_reg;
    logic [31:0] pc_reg, base_reg;
    dec_t   dec_next, dec_reg;
    res_t   res_next, res_reg;

    // Stage advance: a stage loads when it is empty or its successor advances.
    assign adv2    = !v2_reg || m_ready;
    assign adv1    = !v1_reg || adv2;
    assign adv0    = !v0_reg || adv1;
    assign s_ready = adv0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_reg <= 1'b0;
        end else if (cfg_valid) begin
            allow_reg <= cfg_data;
        end
    end

    // Stage 0: input capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv0) begin
            v0_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv0 && s_valid) begin
            hf_reg   <= s_half_first;
            hs_reg   <= s_half_second;
            pc_reg   <= s_insn_addr;
            base_reg <= s_base_addr;
        end
    end

    m16x_decode u_decode (
        .half_first  (hf_reg),
        .half_second (hs_reg),
        .insn_addr   (pc_reg),
        .base_addr   (base_reg),
        .dec         (dec_next)
    );

    // Stage 1: decoded fields.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= v0_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv1 && v0_reg) begin
            dec_reg <= dec_next;
        end
    end

    m16x_resolve u_resolve (
        .allow_64bit (allow_reg),
        .dec         (dec_reg),
        .res         (res_next)
    );

    // Stage 2: output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = v2_reg;
    assign m_outcome       = res_reg.outcome;
    assign m_expanded_word = res_reg.word;
    assign m_place_kind    = res_reg.kind;
    assign m_target_addr   = res_reg.target;
    assign m_src_reg       = res_reg.src;
    assign m_dst_reg       = res_reg.dst;
    assign m_compact_br    = res_reg.ends;
    assign m_link_jump     = res_reg.isbr;

    `M16X_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(res_reg), "output changed while stalled")
    `M16X_ASSERT_IMPL(a_kind_direct, aclk, aresetn, m_valid && m_outcome != OUT_DIRECT,
        m_place_kind == PK_NONE && m_target_addr == 32'd0, "placement set on non-direct")
    `M16X_ASSERT_NEXT(a_stage_move, aclk, aresetn, v1_reg && adv2, v2_reg,
        "decoded request lost before output")
    `M16X_ASSERT_IMPL(a_word_zero, aclk, aresetn, m_valid && m_outcome != OUT_WORD,
        m_expanded_word == 32'd0, "word set on non-word result")

endmodule

`default_nettype wire

// ===== tb/mips16_instruction_expander_tb.sv =====
// ---------------------------------------------------------------------------
// MIPS16 instruction expander testbench
// Drives halfwords with PC and base, predicts each expansion in a scoreboard
// class and checks every response field in order; sweeps allow_64bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import m16x_pkg::*;

typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] word;
    logic [3:0]  kind;
    logic [31:0] target;
    logic [4:0]  src;
    logic [4:0]  dst;
    logic        ends;
    logic        isbr;
} expansion_t;

class expansion_scoreboard;
    expansion_t pending[$];
    bit         wide_ok;
    int         errors;

    function logic [4:0] reg3(input logic [2:0] v);
        logic [4:0] r;
        if (v == 3'd0) r = 5'd16;
        else if (v == 3'd1) r = 5'd17;
        else r = {2'b00, v};
        return r;
    endfunction

    function logic [31:0] iword(input logic [5:0] op, input logic [4:0] rs,
                                input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function logic [31:0] rword(input logic [4:0] rs, input logic [4:0] rt,
                                input logic [4:0] rd, input logic [4:0] sa,
                                input logic [5:0] fn);
        return {6'd0, rs, rt, rd, sa, fn};
    endfunction

    // doubleword form: reserved unless enabled
    function void wide(ref expansion_t e, input logic [31:0] w);
        if (wide_ok) begin
            e.outcome = OUT_WORD;
            e.word = w;
        end else begin
            e.outcome = OUT_RESERVED;
        end
    endfunction

    function void plain(ref expansion_t e, input logic [31:0] w);
        e.outcome = OUT_WORD;
        e.word = w;
    endfunction

    function void place(ref expansion_t e, input logic [3:0] k, input logic [31:0] t);
        e.outcome = OUT_DIRECT;
        e.kind = k;
        e.target = t;
    endfunction

    function void decode_rr(ref expansion_t e, input logic [15:0] h);
        logic [4:0] rx, ry, sa8;
        rx = reg3(h[10:8]);
        ry = reg3(h[7:5]);
        sa8 = (h[10:8] == 3'd0) ? 5'd8 : {2'b00, h[10:8]};
        case (h[4:0])
            5'h00: begin
                if (h[7:5] == 3'd0) plain(e, rword(rx, 5'd0, 5'd0, 5'd0, FN_JR));
                else if (h[7:5] == 3'd1) plain(e, rword(REG_RA, 5'd0, 5'd0, 5'd0, FN_JR));
                else if (h[7:5] == 3'd2) begin
                    place(e, PK_JALR, 32'd0);
                    e.src = rx;
                    e.isbr = 1'b1;
                end else e.outcome = OUT_RESERVED;
            end
            5'h02: plain(e, rword(rx, ry, REG_T, 5'd0, FN_SLT));
            5'h03: plain(e, rword(rx, ry, REG_T, 5'd0, FN_SLTU));
            5'h04: plain(e, rword(rx, ry, ry, 5'd0, FN_SLLV));
            5'h05: plain(e, {20'd0, h[10:5], FN_BREAK});
            5'h06: plain(e, rword(rx, ry, ry, 5'd0, FN_SRLV));
            5'h07: plain(e, rword(rx, ry, ry, 5'd0, FN_SRAV));
            5'h08: wide(e, rword(5'd0, ry, ry, sa8, FN_DSRL));
            5'h09: plain(e, {26'd0, FN_SYSCALL});
            5'h0A: plain(e, rword(rx, ry, REG_T, 5'd0, FN_XOR));
            5'h0B: plain(e, rword(5'd0, ry, rx, 5'd0, FN_SUBU));
            5'h0C: plain(e, rword(rx, ry, rx, 5'd0, FN_AND));
            5'h0D: plain(e, rword(rx, ry, rx, 5'd0, FN_OR));
            5'h0E: plain(e, rword(rx, ry, rx, 5'd0, FN_XOR));
            5'h0F: plain(e, rword(ry, 5'd0, rx, 5'd0, FN_NOR));
            5'h10: plain(e, rword(5'd0, 5'd0, rx, 5'd0, FN_MFHI));
            5'h12: plain(e, rword(5'd0, 5'd0, rx, 5'd0, FN_MFLO));
            5'h13: wide(e, rword(5'd0, ry, ry, sa8, FN_DSRA));
            5'h14: wide(e, rword(rx, ry, ry, 5'd0, FN_DSLLV));
            5'h16: wide(e, rword(rx, ry, ry, 5'd0, FN_DSRLV));
            5'h17: wide(e, rword(rx, ry, ry, 5'd0, FN_DSRAV));
            5'h18: plain(e, rword(rx, ry, 5'd0, 5'd0, FN_MULT));
            5'h19: plain(e, rword(rx, ry, 5'd0, 5'd0, FN_MULTU));
            5'h1A: plain(e, rword(rx, ry, 5'd0, 5'd0, FN_DIV));
            5'h1B: plain(e, rword(rx, ry, 5'd0, 5'd0, FN_DIVU));
            5'h1C: wide(e, rword(rx, ry, 5'd0, 5'd0, FN_DMULT));
            5'h1D: wide(e, rword(rx, ry, 5'd0, 5'd0, FN_DMULTU));
            5'h1E: wide(e, rword(rx, ry, 5'd0, 5'd0, FN_DDIV));
            5'h1F: wide(e, rword(rx, ry, 5'd0, 5'd0, FN_DDIVU));
            default: e.outcome = OUT_RESERVED;
        endcase
    endfunction

    function expansion_t expand(input logic [15:0] h, input logic [15:0] h2,
                                input logic [31:0] pc, input logic [31:0] base);
        expansion_t e;
        logic [4:0]  rx, ry;
        logic [7:0]  i8;
        logic [4:0]  i5, sa;
        logic [31:0] br8, pbase;
        logic [25:0] idx;
        e = '0;
        rx = reg3(h[10:8]);
        ry = reg3(h[7:5]);
        i8 = h[7:0];
        i5 = h[4:0];
        br8 = pc + 32'd2 + {{23{i8[7]}}, i8, 1'b0};
        pbase = (base & ~32'd3) + {22'd0, i8, 2'b00};
        case (h[15:11])
            5'h00: plain(e, iword(OP_ADDIU, REG_SP, rx, {6'd0, i8, 2'b00}));
            5'h01: begin place(e, PK_ADDIUPC, pbase); e.dst = rx; end
            5'h02: begin
                place(e, PK_B, pc + 32'd2 + {{20{h[10]}}, h[10:0], 1'b0});
                e.ends = 1'b1;
            end
            5'h03: begin
                idx = {h[4:0], h[9:5], h2};
                place(e, h[10] ? PK_JALX : PK_JAL,
                      ((pc + 32'd4) & SEG_MASK) | {4'd0, idx, 2'b00});
                e.isbr = 1'b1;
            end
            5'h04, 5'h05: begin
                place(e, h[11] ? PK_BNEZ : PK_BEQZ, br8);
                e.src = rx;
                e.ends = 1'b1;
            end
            5'h06: begin
                sa = (h[4:2] == 3'd0) ? 5'd8 : {2'b00, h[4:2]};
                case (h[1:0])
                    2'd0: plain(e, rword(5'd0, ry, rx, sa, FN_SLL));
                    2'd1: wide(e, rword(5'd0, ry, rx, sa, FN_DSLL));
                    2'd2: plain(e, rword(5'd0, ry, rx, sa, FN_SRL));
                    default: plain(e, rword(5'd0, ry, rx, sa, FN_SRA));
                endcase
            end
            5'h07: wide(e, iword(OP_LD, rx, ry, {8'd0, i5, 3'd0}));
            5'h08: begin
                if (h[4]) wide(e, iword(OP_DADDIU, rx, ry, {{12{h[3]}}, h[3:0]}));
                else plain(e, iword(OP_ADDIU, rx, ry, {{12{h[3]}}, h[3:0]}));
            end
            5'h09: plain(e, iword(OP_ADDIU, rx, rx, {{8{i8[7]}}, i8}));
            5'h0A: plain(e, iword(OP_SLTI, rx, REG_T, {8'd0, i8}));
            5'h0B: plain(e, iword(OP_SLTIU, rx, REG_T, {8'd0, i8}));
            5'h0C: begin
                case (h[10:8])
                    3'd0, 3'd1: begin
                        place(e, h[8] ? PK_BNEZ : PK_BEQZ, br8);
                        e.src = REG_T;
                        e.ends = 1'b1;
                    end
                    3'd2: plain(e, iword(OP_SW, REG_SP, REG_RA, {6'd0, i8, 2'b00}));
                    3'd3: plain(e, iword(OP_ADDIU, REG_SP, REG_SP,
                                         {{5{i8[7]}}, i8, 3'd0}));
                    3'd5: plain(e, rword(reg3(h[2:0]), 5'd0, {h[4:3], h[7:5]}, 5'd0,
                                         FN_OR));
                    3'd7: plain(e, rword(i5, 5'd0, ry, 5'd0, FN_OR));
                    default: e.outcome = OUT_RESERVED;
                endcase
            end
            5'h0D: plain(e, iword(OP_ORI, 5'd0, rx, {8'd0, i8}));
            5'h0E: plain(e, iword(OP_XORI, rx, REG_T, {8'd0, i8}));
            5'h0F: wide(e, iword(OP_SD, rx, ry, {8'd0, i5, 3'd0}));
            5'h10: plain(e, iword(OP_LB, rx, ry, {11'd0, i5}));
            5'h11: plain(e, iword(OP_LH, rx, ry, {10'd0, i5, 1'b0}));
            5'h12: plain(e, iword(OP_LW, REG_SP, rx, {6'd0, i8, 2'b00}));
            5'h13: plain(e, iword(OP_LW, rx, ry, {9'd0, i5, 2'b00}));
            5'h14: plain(e, iword(OP_LBU, rx, ry, {11'd0, i5}));
            5'h15: plain(e, iword(OP_LHU, rx, ry, {10'd0, i5, 1'b0}));
            5'h16: begin place(e, PK_LWPC, pbase); e.dst = rx; end
            5'h17: wide(e, iword(OP_LWU, rx, ry, {9'd0, i5, 2'b00}));
            5'h18: plain(e, iword(OP_SB, rx, ry, {11'd0, i5}));
            5'h19: plain(e, iword(OP_SH, rx, ry, {10'd0, i5, 1'b0}));
            5'h1A: plain(e, iword(OP_SW, REG_SP, rx, {6'd0, i8, 2'b00}));
            5'h1B: plain(e, iword(OP_SW, rx, ry, {9'd0, i5, 2'b00}));
            5'h1C: begin
                case (h[1:0])
                    2'd0: wide(e, rword(rx, ry, reg3(h[4:2]), 5'd0, FN_DADDU));
                    2'd1: plain(e, rword(rx, ry, reg3(h[4:2]), 5'd0, FN_ADDU));
                    2'd2: wide(e, rword(rx, ry, reg3(h[4:2]), 5'd0, FN_DSUBU));
                    default: plain(e, rword(rx, ry, reg3(h[4:2]), 5'd0, FN_SUBU));
                endcase
            end
            5'h1D: decode_rr(e, h);
            default: e.outcome = OUT_NOTCOV;
        endcase
        return e;
    endfunction

    function void note_request(input logic [15:0] h, input logic [15:0] h2,
                               input logic [31:0] pc, input logic [31:0] base);
        pending.push_back(expand(h, h2, pc, base));
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic check_response(input expansion_t got);
        expansion_t want;
        if (pending.size() == 0) begin
            report("unexpected response", 32'(got.outcome), 0);
            return;
        end
        want = pending.pop_front();
        if (got.outcome != want.outcome) report("outcome", 32'(got.outcome), 32'(want.outcome));
        if (got.word != want.word) report("expanded_word", got.word, want.word);
        if (got.kind != want.kind) report("place_kind", 32'(got.kind), 32'(want.kind));
        if (got.target != want.target) report("target_addr", got.target, want.target);
        if (got.src != want.src) report("src_reg", 32'(got.src), 32'(want.src));
        if (got.dst != want.dst) report("dst_reg", 32'(got.dst), 32'(want.dst));
        if (got.ends != want.ends) report("compact_br", 32'(got.ends), 32'(want.ends));
        if (got.isbr != want.isbr) report("link_jump", 32'(got.isbr), 32'(want.isbr));
    endtask
endclass

module mips16_instruction_expander_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 440;
    localparam int HOLD_CYCLES = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [15:0] s_half_first = '0;
    logic [15:0] s_half_second = '0;
    logic [31:0] s_insn_addr = '0;
    logic [31:0] s_base_addr = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [1:0]  m_outcome;
    wire  [31:0] m_expanded_word;
    wire  [3:0]  m_place_kind;
    wire  [31:0] m_target_addr;
    wire  [4:0]  m_src_reg;
    wire  [4:0]  m_dst_reg;
    wire         m_compact_br;
    wire         m_link_jump;

    expansion_scoreboard sb;
    int  idle_cycles;      // cycles with no handshake on any channel
    bit  hold_req;         // stimulus asks the sink for one long stall
    bit  hold_off;         // sink is in its long stall
    bit  sink_random;

    always #5 aclk = ~aclk;

    mips16_instruction_expander u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_half_first   (s_half_first),
        .s_half_second  (s_half_second),
        .s_insn_addr    (s_insn_addr),
        .s_base_addr    (s_base_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_outcome      (m_outcome),
        .m_expanded_word(m_expanded_word),
        .m_place_kind   (m_place_kind),
        .m_target_addr  (m_target_addr),
        .m_src_reg      (m_src_reg),
        .m_dst_reg      (m_dst_reg),
        .m_compact_br   (m_compact_br),
        .m_link_jump    (m_link_jump)
    );

    // Write allow_64bit; the block is idle whenever this is called.
    task automatic write_wide_enable(input bit en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do @(posedge aclk); while (!cfg_ready);
        sb.wide_ok = en;
        cfg_valid <= 1'b0;
    endtask

    // Offer one request, with a random gap ahead of it when asked.
    // Valid drops only for a gap, so back-to-back requests keep it high.
    task automatic send_request(input logic [15:0] h, input logic [15:0] h2,
                                input logic [31:0] pc, input logic [31:0] base,
                                input bit gaps);
        int gap;
        gap = gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_half_first  <= h;
        s_half_second <= h2;
        s_insn_addr   <= pc;
        s_base_addr   <= base;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(h, h2, pc, base);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Mostly real opcodes: bias the major field toward RR, with random fields over every cell.
    task automatic random_request(input bit gaps);
        logic [15:0] h;
        h = 16'($urandom);
        if ($urandom_range(0, 3) == 0) h[15:11] = 5'h1D;
        send_request(h, 16'($urandom), $urandom, $urandom, gaps);
    endtask

    // Response side: random stalls per response, plus the long hold-off.
    initial begin
        int wait_n;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off = 1'b0;
            end else if (!m_ready) m_ready <= 1'b1;
            else if (m_valid) begin
                wait_n = sink_random ? ($urandom_range(0, 3) == 0 ?
                                        $urandom_range(1, 19) : 0) : 0;
                if (wait_n != 0) begin
                    m_ready <= 1'b0;
                    repeat (wait_n - 1) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        expansion_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_outcome, m_expanded_word, m_place_kind, m_target_addr,
                    m_src_reg, m_dst_reg, m_compact_br, m_link_jump};
            sb.check_response(got);
        end
    end

    // Watchdog on cycles with no accepted request of any kind.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn || (!s_valid && sb.pending.size() == 0) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mips16_instruction_expander_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [15:0] corner[$];
        sb = new();
        idle_cycles = 0;
        hold_req = 1'b0;
        hold_off = 1'b0;
        sink_random = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset value of allow_64bit is 0, doubleword forms reserved.
        corner = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h1000, 16'h17FF, 16'h1400,
                   16'h1BFF, 16'h1C00, 16'h3000, 16'h3001, 16'h37FF, 16'h3800,
                   16'h4010, 16'h6080, 16'h6300, 16'h64FF, 16'h6600, 16'h6A1F,
                   16'h67FF, 16'hE800, 16'hE820, 16'hE840, 16'hE8E0, 16'hE801,
                   16'hE808};
        foreach (corner[i])
            send_request(corner[i], 16'hFFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        send_request(16'h2000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        drain();
        write_wide_enable(1'b1);
        foreach (corner[i])
            send_request(corner[i], 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        drain();

        sink_random = 1'b1;
        for (int i = 0; i < RANDOM_REQUESTS / 2; i++) random_request(1'b1);
        drain();

        write_wide_enable(1'b0);
        // Back-pressure: sink stops while the source keeps offering requests.
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) random_request(1'b0);
        for (int i = 0; i < RANDOM_REQUESTS / 2; i++) random_request(1'b1);
        drain();
        write_wide_enable(1'b1);
        for (int i = 0; i < 40; i++) random_request(1'b0);
        drain();

        if (sb.errors == 0)
            $display("mips16_instruction_expander_tb OK");
        else
            $display("mips16_instruction_expander_tb NOT OK");
        $finish;
    end

endmodule

// ===== mips16_instruction_expander.f =====
+incdir+hdl
hdl/m16x_pkg.sv
hdl/m16x_decode.sv
hdl/m16x_resolve.sv
hdl/mips16_instruction_expander.sv
tb/mips16_instruction_expander_tb.sv
